### hdl/cst_pkg.sv
package cst_pkg;

    // Default sizes of the table
    localparam int NUM_SEMS_DEF   = 64;
    localparam int WAIT_DEPTH_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Depth of the command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // Action codes as they arrive on the input stream
    typedef enum logic [2:0] {
        ACT_CREATE  = 3'd0,
        ACT_DESTROY = 3'd1,
        ACT_OPEN    = 3'd2,
        ACT_POST    = 3'd3,
        ACT_WAIT    = 3'd4,
        ACT_TRYWAIT = 3'd5
    } action_t;

    // Classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_CREATE,
        OP_DESTROY,
        OP_OPEN,
        OP_POST,
        OP_WAIT,
        OP_TRYWAIT,
        OP_BAD
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_WOULD_BLOCK = 3'd2,
        ST_QUEUED      = 3'd3,
        ST_QUEUE_FULL  = 3'd4,
        ST_SATURATED   = 3'd5
    } status_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC,
        BS_WAKE
    } back_state_t;

    // One classified command
    typedef struct packed {
        op_t         op;
        logic [5:0]  sem;
        logic [15:0] init;
        logic        init_sat;
        logic [7:0]  pid;
    } cmd_t;

    // Status from back end to front end
    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

### hdl/cst_front.sv
module cst_front #(
    parameter int NUM_SEMS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // tdata: action[2:0], sem_id[8:3], init_value[24:9], process_id[32:25], zero pad
    input  logic [39:0]             s_tdata,
    input  cst_pkg::back_stat_t     stat,
    output logic                    push,
    input  logic                    push_ready,
    output cst_pkg::cmd_t           cmd
);
    import cst_pkg::*;

    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    logic [2:0]  action;
    logic [5:0]  sem_id;
    logic [15:0] init_value;
    logic [7:0]  process_id;
    logic        id_ok;
    logic        sat;
    op_t         op;

    // Unpack the input word
    assign action     = s_tdata[2:0];
    assign sem_id     = s_tdata[8:3];
    assign init_value = s_tdata[24:9];
    assign process_id = s_tdata[32:25];

    // Hold off input while the table is being cleared
    assign s_tready = push_ready && !stat.clearing;
    assign push     = s_tvalid && s_tready;

    assign id_ok = {26'd0, sem_id} < NUM_SEMS;
    assign sat   = {17'd0, init_value} > COUNT_MAX;

    // Classify the action
    always_comb begin
        unique case (action)
            ACT_CREATE:  op = OP_CREATE;
            ACT_DESTROY: op = OP_DESTROY;
            ACT_OPEN:    op = OP_OPEN;
            ACT_POST:    op = OP_POST;
            ACT_WAIT:    op = OP_WAIT;
            ACT_TRYWAIT: op = OP_TRYWAIT;
            default:     op = OP_BAD;
        endcase
    end

    // Build the command; fold bad ids into a no-op and clamp the start count
    always_comb begin
        cmd.op       = id_ok ? op : OP_BAD;
        cmd.sem      = id_ok ? sem_id : 6'd0;
        cmd.init     = sat ? COUNT_MAX[15:0] : init_value;
        cmd.init_sat = sat;
        cmd.pid      = process_id;
    end

endmodule

### hdl/cst_cmd_fifo.sv
module cst_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cst_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output cst_pkg::cmd_t out_cmd
);
    import cst_pkg::*;

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             slot_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign in_ready  = cnt_reg != CNT_W'(CMD_FIFO_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                        : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                        : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### hdl/cst_back.sv
module cst_back #(
    parameter int NUM_SEMS   = 64,
    parameter int WAIT_DEPTH = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_valid,
    output logic                fifo_pop,
    input  cst_pkg::cmd_t       fifo_cmd,
    output cst_pkg::back_stat_t stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata: status[2:0], wake_valid[3], wake_process[11:4], zero pad
    output logic [15:0]         m_tdata
);
    import cst_pkg::*;

    localparam int IDX_W   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PTR_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int LEN_W   = $clog2(WAIT_DEPTH + 1);
    localparam int WADDR_W = $clog2(NUM_SEMS * WAIT_DEPTH);

    typedef struct packed {
        logic                  used;
        logic [COUNT_BITS-1:0] count;
        logic [PTR_W-1:0]      head;
        logic [PTR_W-1:0]      tail;
        logic [LEN_W-1:0]      len;
    } rec_t;

    // Semaphore records and waiter slots
    rec_t       rec_mem [NUM_SEMS];
    logic [7:0] wq_mem  [NUM_SEMS * WAIT_DEPTH];

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    cmd_t             cmd_reg, cmd_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic             out_wv_reg, out_wv_next;
    logic [7:0]       out_wp_reg, out_wp_next;
    rec_t             rec_rd_reg;
    logic [7:0]       wq_rd_reg;

    logic               out_ready;
    logic [IDX_W-1:0]   cmd_idx;
    logic               rec_re, rec_we;
    logic [IDX_W-1:0]   rec_ra, rec_wa;
    rec_t               rec_wd;
    logic               wq_we, wq_re;
    logic [WADDR_W-1:0] wq_wa, wq_ra;

    rec_t    ex_rec;
    status_t ex_status;
    logic    ex_wr, ex_wake, ex_enq;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(WAIT_DEPTH - 1))
            return '0;
        else
            return PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [WADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] idx,
                                                     input logic [PTR_W-1:0] ptr);
        return WADDR_W'(WADDR_W'(idx) * WADDR_W'(WAIT_DEPTH)) + WADDR_W'(ptr);
    endfunction

    assign out_ready = !out_valid_reg || m_tready;
    assign cmd_idx   = IDX_W'(cmd_reg.sem);
    assign rec_ra    = IDX_W'(fifo_cmd.sem);
    assign wq_wa     = slot_addr(cmd_idx, rec_rd_reg.tail);
    assign wq_ra     = slot_addr(cmd_idx, rec_rd_reg.head);

    assign stat.clearing = state_reg == BS_CLEAR;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {4'd0, out_wp_reg, out_wv_reg, out_status_reg};

    // Carry out the command on the record that was read
    always_comb begin
        ex_rec    = rec_rd_reg;
        ex_status = ST_INVALID;
        ex_wr     = 1'b0;
        ex_wake   = 1'b0;
        ex_enq    = 1'b0;
        unique case (cmd_reg.op)
            OP_CREATE:
            begin
                if (!rec_rd_reg.used)
                begin
                    ex_rec.used  = 1'b1;
                    ex_rec.count = COUNT_BITS'(cmd_reg.init);
                    ex_rec.head  = '0;
                    ex_rec.tail  = '0;
                    ex_rec.len   = '0;
                    ex_wr        = 1'b1;
                    ex_status    = cmd_reg.init_sat ? ST_SATURATED : ST_OK;
                end
            end
            OP_DESTROY:
            begin
                if (rec_rd_reg.used)
                begin
                    ex_rec    = '0;
                    ex_wr     = 1'b1;
                    ex_status = ST_OK;
                end
            end
            OP_OPEN:
            begin
                if (rec_rd_reg.used)
                begin
                    ex_status = ST_OK;
                end
            end
            OP_POST:
            begin
                if (rec_rd_reg.used)
                begin
                    if (rec_rd_reg.len != '0)
                    begin
                        ex_rec.head = next_slot(rec_rd_reg.head);
                        ex_rec.len  = LEN_W'(rec_rd_reg.len - 1'b1);
                        ex_wr       = 1'b1;
                        ex_wake     = 1'b1;
                        ex_status   = ST_OK;
                    end
                    else if (&rec_rd_reg.count)
                    begin
                        ex_status = ST_SATURATED;
                    end
                    else
                    begin
                        ex_rec.count = COUNT_BITS'(rec_rd_reg.count + 1'b1);
                        ex_wr        = 1'b1;
                        ex_status    = ST_OK;
                    end
                end
            end
            OP_WAIT:
            begin
                if (rec_rd_reg.used)
                begin
                    if (rec_rd_reg.count != '0)
                    begin
                        ex_rec.count = COUNT_BITS'(rec_rd_reg.count - 1'b1);
                        ex_wr        = 1'b1;
                        ex_status    = ST_OK;
                    end
                    else if (rec_rd_reg.len == LEN_W'(WAIT_DEPTH))
                    begin
                        ex_status = ST_QUEUE_FULL;
                    end
                    else
                    begin
                        ex_rec.tail = next_slot(rec_rd_reg.tail);
                        ex_rec.len  = LEN_W'(rec_rd_reg.len + 1'b1);
                        ex_wr       = 1'b1;
                        ex_enq      = 1'b1;
                        ex_status   = ST_QUEUED;
                    end
                end
            end
            OP_TRYWAIT:
            begin
                if (rec_rd_reg.used)
                begin
                    if (rec_rd_reg.count != '0)
                    begin
                        ex_rec.count = COUNT_BITS'(rec_rd_reg.count - 1'b1);
                        ex_wr        = 1'b1;
                        ex_status    = ST_OK;
                    end
                    else
                    begin
                        ex_status = ST_WOULD_BLOCK;
                    end
                end
            end
            default:
            begin
                ex_status = ST_INVALID;
            end
        endcase
    end

    // Sequence clear, read, execute and wake steps
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_wv_next     = out_wv_reg;
        out_wp_next     = out_wp_reg;
        fifo_pop        = 1'b0;
        rec_re          = 1'b0;
        rec_we          = 1'b0;
        rec_wa          = cmd_idx;
        rec_wd          = ex_rec;
        wq_we           = 1'b0;
        wq_re           = 1'b0;
        unique case (state_reg)
            BS_CLEAR:
            begin
                rec_we = 1'b1;
                rec_wa = clr_reg;
                rec_wd = '0;
                if (clr_reg == IDX_W'(NUM_SEMS - 1))
                    state_next = BS_IDLE;
                else
                    clr_next = IDX_W'(clr_reg + 1'b1);
            end
            BS_IDLE:
            begin
                if (fifo_valid)
                begin
                    fifo_pop   = 1'b1;
                    rec_re     = 1'b1;
                    cmd_next   = fifo_cmd;
                    state_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                if (ex_wake || out_ready)
                begin
                    rec_we = ex_wr;
                    wq_we  = ex_enq;
                    wq_re  = ex_wake;
                    if (ex_wake)
                    begin
                        state_next = BS_WAKE;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ex_status;
                        out_wv_next     = 1'b0;
                        out_wp_next     = '0;
                        state_next      = BS_IDLE;
                    end
                end
            end
            BS_WAKE:
            begin
                if (out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_wv_next     = 1'b1;
                    out_wp_next     = wq_rd_reg;
                    state_next      = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BS_CLEAR;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_wv_reg     <= 1'b0;
            out_wp_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_wv_reg     <= out_wv_next;
            out_wp_reg     <= out_wp_next;
        end
    end

    // Hold the command under execution
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Record and waiter memories with registered reads
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_wa] <= rec_wd;
        end
        if (rec_re)
        begin
            rec_rd_reg <= rec_mem[rec_ra];
        end
        if (wq_we)
        begin
            wq_mem[wq_wa] <= cmd_reg.pid;
        end
        if (wq_re)
        begin
            wq_rd_reg <= wq_mem[wq_ra];
        end
    end

`ifndef SYNTHESIS
    a_rec_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        rec_we |-> (state_reg == BS_CLEAR || state_reg == BS_EXEC))
        else $error("record write outside clear or execute");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_CLEAR) |-> !fifo_pop)
        else $error("command taken during clearing pass");

    a_wake_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_wv_reg) |-> (out_status_reg == ST_OK))
        else $error("wake result without ok status");

    a_no_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_wv_reg) |-> (out_wp_reg == '0))
        else $error("process number set without wake");

    a_exec_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_EXEC && (ex_wake || out_ready))
        |=> (state_reg == BS_IDLE || state_reg == BS_WAKE))
        else $error("execute step did not retire");
`endif

endmodule

### hdl/counting_semaphore_table_core.sv
// An input word enters the command queue; the back end registers it with its record
// and then its result word; a waking post registers a waiter slot read before the result.
// The back end holds one word at a time through the read-modify-write of its record
// and stalls on back-pressure. Reset: asynchronous, active low; then a clearing pass
// zeroes all NUM_SEMS records while input is held off. Waiter slots are not cleared.
module counting_semaphore_table_core #(
    parameter int NUM_SEMS   = cst_pkg::NUM_SEMS_DEF,
    parameter int WAIT_DEPTH = cst_pkg::WAIT_DEPTH_DEF,
    parameter int COUNT_BITS = cst_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: action[2:0], sem_id[8:3], init_value[24:9], process_id[32:25], zero pad
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[2:0], wake_valid[3], wake_process[11:4], zero pad
    output logic [15:0] m_tdata
);
    import cst_pkg::*;

    cmd_t       front_cmd;
    cmd_t       fifo_cmd;
    back_stat_t stat;
    logic       push, push_ready;
    logic       fifo_valid, fifo_pop;

    // Accept and classify input words
    cst_front #(
        .NUM_SEMS   (NUM_SEMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .stat       (stat),
        .push       (push),
        .push_ready (push_ready),
        .cmd        (front_cmd)
    );

    // Buffer commands between front and back
    cst_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (push_ready),
        .in_cmd    (front_cmd),
        .out_valid (fifo_valid),
        .out_ready (fifo_pop),
        .out_cmd   (fifo_cmd)
    );

    // Execute commands against the semaphore table
    cst_back #(
        .NUM_SEMS   (NUM_SEMS),
        .WAIT_DEPTH (WAIT_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (fifo_valid),
        .fifo_pop   (fifo_pop),
        .fifo_cmd   (fifo_cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### verif/semaphore_call_checker.sv
`timescale 1ns / 1ps

// Watch both stream channels of the semaphore table, predict each reply
// from its call word and compare it with the reply word that comes out.
module semaphore_call_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // tdata: action, sem_id, init_value, process_id, zero pad
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status, wake_valid, wake_process, zero pad
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import cst_pkg::*;

    localparam int unsigned COUNT_TOP = 32'((64'd1 << COUNT_BITS_DEF) - 64'd1);

    typedef struct {
        status_t    status;
        logic       woke;
        logic [7:0] woken_pid;
    } reply_t;

    // Shadow copy of the semaphore table
    bit          sem_busy   [NUM_SEMS_DEF];
    int unsigned sem_units  [NUM_SEMS_DEF];
    int unsigned q_head     [NUM_SEMS_DEF];
    int unsigned q_tail     [NUM_SEMS_DEF];
    int unsigned q_len      [NUM_SEMS_DEF];
    bit [7:0]    waiting_pid[NUM_SEMS_DEF][WAIT_DEPTH_DEF];

    reply_t      replies[$];
    int          mismatches;

    // Apply one call to the shadow table and return the reply it earns
    function automatic reply_t semaphore_call(logic [2:0] act, logic [5:0] id,
                                              logic [15:0] init, logic [7:0] pid);
        reply_t      r;
        bit          in_range;
        bit          opened;
        int unsigned s;
        int unsigned units;
        r.status    = ST_INVALID;
        r.woke      = 1'b0;
        r.woken_pid = 8'd0;
        in_range    = id < NUM_SEMS_DEF;
        s           = in_range ? 32'(id) : 32'd0;
        opened      = in_range && sem_busy[s];
        case (act)
            ACT_CREATE:
            begin
                if (in_range && !sem_busy[s])
                begin
                    r.status = ST_OK;
                    units    = 32'(init);
                    // clamp a start count wider than the counter
                    if (units > COUNT_TOP)
                    begin
                        units    = COUNT_TOP;
                        r.status = ST_SATURATED;
                    end
                    sem_busy[s]  = 1'b1;
                    sem_units[s] = units;
                    q_head[s]    = 0;
                    q_tail[s]    = 0;
                    q_len[s]     = 0;
                end
            end
            ACT_DESTROY:
            begin
                if (opened)
                begin
                    sem_busy[s]  = 1'b0;
                    sem_units[s] = 0;
                    q_head[s]    = 0;
                    q_tail[s]    = 0;
                    q_len[s]     = 0;
                    r.status     = ST_OK;
                end
            end
            ACT_OPEN:
            begin
                if (opened)
                    r.status = ST_OK;
            end
            ACT_POST:
            begin
                if (opened)
                begin
                    // release the oldest waiter first, else raise the count
                    if (q_len[s] > 0)
                    begin
                        r.woke      = 1'b1;
                        r.woken_pid = waiting_pid[s][q_head[s]];
                        q_head[s]   = (q_head[s] + 1) % WAIT_DEPTH_DEF;
                        q_len[s]    = q_len[s] - 1;
                        r.status    = ST_OK;
                    end
                    else if (sem_units[s] >= COUNT_TOP)
                        r.status = ST_SATURATED;
                    else
                    begin
                        sem_units[s] = sem_units[s] + 1;
                        r.status     = ST_OK;
                    end
                end
            end
            ACT_WAIT:
            begin
                if (opened)
                begin
                    if (sem_units[s] > 0)
                    begin
                        sem_units[s] = sem_units[s] - 1;
                        r.status     = ST_OK;
                    end
                    else if (q_len[s] >= WAIT_DEPTH_DEF)
                        r.status = ST_QUEUE_FULL;
                    else
                    begin
                        waiting_pid[s][q_tail[s]] = pid;
                        q_tail[s] = (q_tail[s] + 1) % WAIT_DEPTH_DEF;
                        q_len[s]  = q_len[s] + 1;
                        r.status  = ST_QUEUED;
                    end
                end
            end
            ACT_TRYWAIT:
            begin
                if (opened)
                begin
                    if (sem_units[s] > 0)
                    begin
                        sem_units[s] = sem_units[s] - 1;
                        r.status     = ST_OK;
                    end
                    else
                        r.status = ST_WOULD_BLOCK;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Match reply words against the oldest prediction, then queue new ones
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies.size() == 0)
                begin
                    $display("%0t: reply word %h arrived with no call outstanding",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = replies.pop_front();
                    if (m_tdata[2:0] !== want.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                        mismatches++;
                    end
                    if (m_tdata[3] !== want.woke)
                    begin
                        $display("%0t: wake_valid expected %0d, actual %0d",
                                 $time, want.woke, m_tdata[3]);
                        mismatches++;
                    end
                    if (m_tdata[11:4] !== want.woken_pid)
                    begin
                        $display("%0t: wake_process expected %0d, actual %0d",
                                 $time, want.woken_pid, m_tdata[11:4]);
                        mismatches++;
                    end
                    if (m_tdata[15:12] !== 4'd0)
                    begin
                        $display("%0t: pad bits expected 0, actual %h",
                                 $time, m_tdata[15:12]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                replies.push_back(semaphore_call(s_tdata[2:0], s_tdata[8:3],
                                                 s_tdata[24:9], s_tdata[32:25]));
        end
        fail_count <= mismatches;
        pending    <= replies.size();
    end

endmodule

### verif/tb_counting_semaphore_table_core.sv
`timescale 1ns / 1ps

module tb_counting_semaphore_table_core;
    import cst_pkg::*;

    localparam int          CALL_COUNT  = 1450;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [2:0]  ACT_SPARE_A = 3'd6;
    localparam logic [2:0]  ACT_SPARE_B = 3'd7;
    localparam logic [15:0] UNITS_MAX   = 16'hFFFF;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // tdata: action[2:0], sem_id[8:3], init_value[24:9], process_id[32:25], zero pad
    logic [39:0] s_tdata  = 40'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tdata: status[2:0], wake_valid[3], wake_process[11:4], zero pad
    logic [15:0] m_tdata;

    int          fail_count;
    int          pending;
    int          sent;
    bit          steady_send;
    logic        hold_req = 1'b0;

    counting_semaphore_table_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    semaphore_call_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // Sender idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one call word and hold it until the block takes it
    task automatic send_call(logic [2:0] act, logic [5:0] id,
                             logic [15:0] init, logic [7:0] pid);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pid, init, id, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Drop valid and wait until every reply is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [2:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return ACT_CREATE;
        else if (r < 12)
            return ACT_DESTROY;
        else if (r < 17)
            return ACT_OPEN;
        else if (r < 42)
            return ACT_POST;
        else if (r < 77)
            return ACT_WAIT;
        else if (r < 94)
            return ACT_TRYWAIT;
        else
            return $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    endfunction

    function automatic logic [15:0] pick_units();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, 2));
        else if (r < 70)
            return 16'($urandom_range(0, 65535));
        else if (r < 85)
            return UNITS_MAX;
        else
            return UNITS_MAX - 16'($urandom_range(0, 5));
    endfunction

    // Fill a wait queue up to or past its depth, then release it with posts and some trywaits
    task automatic queue_burst();
        logic [5:0] id;
        int         depth;
        id    = 6'($urandom_range(0, 63));
        depth = $urandom_range(WAIT_DEPTH_DEF - 4, WAIT_DEPTH_DEF + 3);
        send_call(ACT_DESTROY, id, 16'd0, 8'd0);
        send_call(ACT_CREATE, id, 16'($urandom_range(0, 2)), 8'd0);
        repeat (depth)
            send_call(ACT_WAIT, id, 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)));
        repeat (depth + $urandom_range(0, 3))
        begin
            if ($urandom_range(0, 4) == 0)
                send_call(ACT_TRYWAIT, id, 16'd0, 8'($urandom_range(0, 255)));
            else
                send_call(ACT_POST, id, 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)));
        end
    endtask

    // Push a count up against its ceiling
    task automatic ceiling_burst();
        logic [5:0] id;
        id = 6'($urandom_range(0, 63));
        send_call(ACT_DESTROY, id, 16'd0, 8'd0);
        send_call(ACT_CREATE, id, UNITS_MAX - 16'($urandom_range(0, 2)), 8'd0);
        repeat ($urandom_range(2, 5))
            send_call(ACT_POST, id, 16'd0, 8'd0);
        repeat ($urandom_range(1, 3))
            send_call(pick_action(), id, pick_units(), 8'($urandom_range(0, 255)));
    endtask

    // Run timeout
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls, calm windows and one long hold-off
    initial
    begin
        int cyc;
        int r;
        bit hold_done;
        cyc       = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            r = $urandom_range(0, 99);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ((cyc % 1000) < 150)
                m_tready <= 1'b1;
            else if (r < 2)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(15, 50)) @(posedge clk);
            end
            else
                m_tready <= (r >= 30);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int  r;
        bit  paused;
        sent        = 0;
        paused      = 1'b0;
        steady_send = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed calls on the edge ids and values
        send_call(ACT_OPEN,    6'd0,  16'd0,    8'd0);
        send_call(ACT_CREATE,  6'd0,  16'd0,    8'd0);
        send_call(ACT_CREATE,  6'd0,  16'd5,    8'd0);
        send_call(ACT_TRYWAIT, 6'd0,  16'd0,    8'd1);
        send_call(ACT_WAIT,    6'd0,  16'd0,    8'hAA);
        send_call(ACT_WAIT,    6'd0,  16'd0,    8'h55);
        send_call(ACT_POST,    6'd0,  16'd0,    8'd0);
        send_call(ACT_POST,    6'd0,  16'd0,    8'd0);
        send_call(ACT_POST,    6'd0,  16'd0,    8'd0);
        send_call(ACT_TRYWAIT, 6'd0,  16'd0,    8'd0);
        send_call(ACT_CREATE,  6'd63, UNITS_MAX, 8'd0);
        send_call(ACT_POST,    6'd63, 16'd0,    8'd0);
        send_call(ACT_WAIT,    6'd63, 16'd0,    8'hFF);
        send_call(ACT_OPEN,    6'd63, 16'd0,    8'd0);
        send_call(ACT_DESTROY, 6'd63, 16'd0,    8'd0);
        send_call(ACT_DESTROY, 6'd63, 16'd0,    8'd0);
        send_call(ACT_SPARE_A, 6'd0,  16'd0,    8'd0);
        send_call(ACT_SPARE_B, 6'd63, UNITS_MAX, 8'hFF);
        send_call(ACT_WAIT,    6'd0,  16'd0,    8'd0);
        send_call(ACT_DESTROY, 6'd0,  16'd0,    8'd0);
        send_call(ACT_POST,    6'd0,  16'd0,    8'd0);

        // random calls, mostly well-formed sequences on a few ids
        while (sent < CALL_COUNT)
        begin
            steady_send = (sent >= 700 && sent < 850);
            if (sent >= 500 && !hold_req)
                hold_req <= 1'b1;
            if (sent >= 1000 && !paused)
            begin
                paused = 1'b1;
                drain();
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                queue_burst();
            else if (r < 16)
                ceiling_burst();
            else
                send_call(pick_action(),
                          ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 3))
                                                     : 6'($urandom_range(0, 63)),
                          pick_units(), 8'($urandom_range(0, 255)));
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
hdl/cst_pkg.sv
hdl/cst_front.sv
hdl/cst_cmd_fifo.sv
hdl/cst_back.sv
hdl/counting_semaphore_table_core.sv
verif/semaphore_call_checker.sv
verif/tb_counting_semaphore_table_core.sv
